/* design/sbe_pkg.sv */
// shared constants, codes and widths for the stack bytecode executor
// used by the ram wrapper users, the top level and the port checker
`default_nettype none

package sbe_pkg;

  localparam int STACK_DEPTH    = 1024;
  localparam int VARIABLE_DEPTH = 4096;
  localparam int PUSH_LIMIT     = 1000;

  localparam int STK_AW   = $clog2(STACK_DEPTH);
  localparam int HEIGHT_W = $clog2(STACK_DEPTH + 1);
  localparam int VAR_AW   = $clog2(VARIABLE_DEPTH);
  localparam int PUSH_MAX = (PUSH_LIMIT < STACK_DEPTH) ? PUSH_LIMIT : STACK_DEPTH;

  localparam int WORD_W = 32;
  localparam int ACT_W  = 4;
  localparam int OPND_W = 24;
  localparam int STAT_W = 3;
  localparam int GC_W   = 13;
  localparam int PC_W   = 8;
  localparam int VC_W   = 13;
  localparam int FB_W   = 11;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam int FRAME_W = ((HEIGHT_W > FB_W) ? HEIGHT_W : FB_W) + 1;
  localparam int CMP_W   = ((FRAME_W > OPND_W) ? FRAME_W : OPND_W) + 2;
  localparam int PROD_W  = PC_W + 1 + WORD_W;
  localparam int IDX_W   = PROD_W + 2;

  localparam logic [WORD_W-1:0] NIL_WORD = '1;

  localparam logic [GC_W-1:0] GC_RESET = 13'd8;
  localparam logic [PC_W-1:0] PC_RESET = 8'd0;
  localparam logic [VC_W-1:0] VC_RESET = 13'd8;
  localparam logic [FB_W-1:0] FB_RESET = 11'd0;

  localparam logic [1:0] REG_GLOBAL_COUNT   = 2'd0;
  localparam logic [1:0] REG_PROPERTY_COUNT = 2'd1;
  localparam logic [1:0] REG_VARIABLE_COUNT = 2'd2;
  localparam logic [1:0] REG_FRAME_BASE     = 2'd3;

  localparam logic [OPND_W-1:0] SUB_NOT = 24'd0;
  localparam logic [OPND_W-1:0] SUB_AND = 24'd0;
  localparam logic [OPND_W-1:0] SUB_OR  = 24'd1;
  localparam logic [OPND_W-1:0] SUB_EQ  = 24'd2;
  localparam logic [OPND_W-1:0] SUB_NEQ = 24'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_LLI = 4'd0,
    ACT_POP = 4'd1,
    ACT_LDL = 4'd2,
    ACT_STL = 4'd3,
    ACT_LDG = 4'd4,
    ACT_STG = 4'd5,
    ACT_LDI = 4'd6,
    ACT_STI = 4'd7,
    ACT_JNP = 4'd8,
    ACT_JMP = 4'd9,
    ACT_OP1 = 4'd10,
    ACT_OP2 = 4'd11,
    ACT_OP3 = 4'd12,
    ACT_CAL = 4'd13,
    ACT_RET = 4'd14,
    ACT_INV = 4'd15
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CONTINUE = 3'd0,
    ST_RETURNED = 3'd1,
    ST_INVALID  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_CALL     = 3'd4
  } status_t;

endpackage

`default_nettype wire

/* design/sbe_ram.sv */
// generic synchronous ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic                     re_b,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* design/stack_bytecode_executor.sv */
// flow: the instruction and its stack ram reads are registered at the input transfer,
// then the result in the execute state (ldi via index and load, sti via index); a new
// instruction waits for idle, each read depending on the height the last one left
// reset: synchronous, active low; afterwards the variable store is swept to nil,
// one entry a cycle with in_stall high; config writes always taken
// depends on sbe_pkg and sbe_ram
`default_nettype none

module stack_bytecode_executor
  import sbe_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ACT_W-1:0]         in_action,
  input  wire logic signed [OPND_W-1:0] in_operand,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic      [STAT_W-1:0]        out_status,
  output logic                          out_jump_taken,
  output logic signed [OPND_W-1:0]      out_jump_offset,
  output logic signed [WORD_W-1:0]      out_return_value,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_AW-1:0]        cfg_paddr,
  input  wire logic [CFG_DW-1:0]        cfg_pwdata,
  output logic      [CFG_DW-1:0]        cfg_prdata,
  output logic                          cfg_pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_INDEX,
    S_LOAD
  } state_t;

  localparam logic signed [CMP_W-1:0] ONE_S = 1;

  state_t                    state_r, state_nxt;
  logic [HEIGHT_W-1:0]       height_r, height_nxt;
  logic [VAR_AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  action_t                   act_r;
  logic signed [OPND_W-1:0]  arg_r;
  logic signed [PROD_W-1:0]  product_r, product_nxt;
  logic [GC_W-1:0]           gc_r;
  logic [PC_W-1:0]           pc_r;
  logic [VC_W-1:0]           vc_r;
  logic [FB_W-1:0]           fb_r;

  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, res_status;
  logic                      out_jt_r, res_jt;
  logic signed [OPND_W-1:0]  out_joff_r, res_joff;
  logic [WORD_W-1:0]         out_rv_r, res_rv;

  logic                      accept, out_free, done, finish;
  logic [HEIGHT_W-1:0]       height_new;

  logic                      stk_we, stk_we_req;
  logic [STK_AW-1:0]         stk_waddr, stk_raddr_a, stk_raddr_b;
  logic [WORD_W-1:0]         stk_wdata, stk_rd_a, stk_rd_b;
  logic [STK_AW-1:0]         top_addr, next_addr, ldl_addr, stl_addr;

  logic                      var_we, var_we_req;
  logic [VAR_AW-1:0]         var_waddr;
  logic [WORD_W-1:0]         var_wdata, var_rd_a, var_rd_b;

  logic signed [CMP_W-1:0]   frame_s, arg_s, rem_ext;
  logic signed [9:0]         rem_s;
  logic [WORD_W-1:0]         nvar_w, ent;
  logic                      can_push, arg_neg, var_ok, a_zero, b_zero, op2_r;
  logic signed [IDX_W-1:0]   idx_s;
  logic                      idx_ok;
  logic                      cfg_wr;

  // stack and variable store memories
  sbe_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .re_a    (accept),
    .raddr_a (stk_raddr_a),
    .rdata_a (stk_rd_a),
    .re_b    (accept),
    .raddr_b (stk_raddr_b),
    .rdata_b (stk_rd_b)
  );

  // port a serves ldg at transfer time, port b the entity lookup of ldi
  sbe_ram #(.WIDTH(WORD_W), .DEPTH(VARIABLE_DEPTH)) u_vars (
    .clk     (clk),
    .we      (var_we),
    .waddr   (var_waddr),
    .wdata   (var_wdata),
    .re_a    (accept),
    .raddr_a (in_operand[VAR_AW-1:0]),
    .rdata_a (var_rd_a),
    .re_b    (state_r == S_INDEX),
    .raddr_b (idx_s[VAR_AW-1:0]),
    .rdata_b (var_rd_b)
  );

  assign accept   = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign top_addr    = STK_AW'(height_r - HEIGHT_W'(1));
  assign next_addr   = STK_AW'(height_r - HEIGHT_W'(2));
  assign ldl_addr    = STK_AW'(OPND_W'(fb_r) + in_operand);
  assign stl_addr    = STK_AW'(OPND_W'(fb_r) + arg_r);
  assign stk_raddr_a = (in_action == ACT_LDL) ? ldl_addr : top_addr;
  assign stk_raddr_b = next_addr;

  assign frame_s  = CMP_W'(height_r) - CMP_W'(fb_r);
  assign arg_s    = CMP_W'(arg_r);
  assign arg_neg  = arg_r[OPND_W-1];
  assign can_push = 32'(height_r) < 32'(PUSH_MAX);
  assign nvar_w   = (32'(vc_r) < 32'(VARIABLE_DEPTH)) ? 32'(vc_r) : 32'(VARIABLE_DEPTH);
  assign var_ok   = !arg_neg && (32'(arg_r[OPND_W-2:0]) < nvar_w);
  assign a_zero   = (stk_rd_a == '0);
  assign b_zero   = (stk_rd_b == '0);

  // truncating remainder by 256 keeps the sign of the operand
  assign rem_s   = (arg_neg && (arg_r[7:0] != 8'd0)) ? $signed({2'b11, arg_r[7:0]})
                                                     : $signed({2'b00, arg_r[7:0]});
  assign rem_ext = CMP_W'(rem_s);

  assign ent         = (act_r == ACT_LDI) ? stk_rd_a : stk_rd_b;
  assign product_nxt = $signed({1'b0, pc_r}) * $signed(ent);
  assign idx_s       = IDX_W'(gc_r) + IDX_W'(product_r) + IDX_W'(arg_r);
  assign idx_ok      = !idx_s[IDX_W-1] && ($unsigned(idx_s) < IDX_W'(nvar_w));

  always_comb begin
    case (arg_r)
      SUB_AND: op2_r = !a_zero && !b_zero;
      SUB_OR:  op2_r = !a_zero || !b_zero;
      SUB_EQ:  op2_r = (stk_rd_a == stk_rd_b);
      default: op2_r = (stk_rd_a != stk_rd_b);
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    done        = 1'b0;
    height_new  = height_r;
    res_status  = ST_CONTINUE;
    res_jt      = 1'b0;
    res_joff    = '0;
    res_rv      = '0;
    stk_we_req  = 1'b0;
    stk_waddr   = top_addr;
    stk_wdata   = stk_rd_a;
    var_we_req  = 1'b0;
    var_waddr   = arg_r[VAR_AW-1:0];
    var_wdata   = stk_rd_a;

    case (state_r)
      S_CLEAR: begin
        var_we_req  = 1'b1;
        var_waddr   = clr_cnt_r;
        var_wdata   = NIL_WORD;
        clr_cnt_nxt = clr_cnt_r + VAR_AW'(1);
        if (clr_cnt_r == VAR_AW'(VARIABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        done = 1'b1;
        case (act_r)
          ACT_LLI: begin
            if (!can_push) begin
              res_status = ST_OVERFLOW;
            end else begin
              stk_we_req = 1'b1;
              stk_waddr  = STK_AW'(height_r);
              stk_wdata  = WORD_W'(arg_r);
              height_new = height_r + HEIGHT_W'(1);
            end
          end
          ACT_POP: begin
            if (arg_neg || (arg_s > frame_s)) begin
              res_status = ST_INVALID;
            end else begin
              height_new = height_r - arg_r[HEIGHT_W-1:0];
            end
          end
          ACT_LDL: begin
            if (arg_neg || (arg_s >= frame_s)) begin
              res_status = ST_INVALID;
            end else if (!can_push) begin
              res_status = ST_OVERFLOW;
            end else begin
              stk_we_req = 1'b1;
              stk_waddr  = STK_AW'(height_r);
              height_new = height_r + HEIGHT_W'(1);
            end
          end
          ACT_STL: begin
            if (arg_neg || ((arg_s + ONE_S) >= frame_s)) begin
              res_status = ST_INVALID;
            end else begin
              stk_we_req = 1'b1;
              stk_waddr  = stl_addr;
              height_new = height_r - HEIGHT_W'(1);
            end
          end
          ACT_LDG: begin
            if (!var_ok) begin
              res_status = ST_INVALID;
            end else if (!can_push) begin
              res_status = ST_OVERFLOW;
            end else begin
              stk_we_req = 1'b1;
              stk_waddr  = STK_AW'(height_r);
              stk_wdata  = var_rd_a;
              height_new = height_r + HEIGHT_W'(1);
            end
          end
          ACT_STG: begin
            if (!var_ok || (frame_s < ONE_S)) begin
              res_status = ST_INVALID;
            end else begin
              var_we_req = 1'b1;
              height_new = height_r - HEIGHT_W'(1);
            end
          end
          ACT_LDI: begin
            if (frame_s < ONE_S) begin
              res_status = ST_INVALID;
            end else begin
              done      = 1'b0;
              state_nxt = S_INDEX;
            end
          end
          ACT_STI: begin
            if (frame_s <= ONE_S) begin
              res_status = ST_INVALID;
            end else begin
              done      = 1'b0;
              state_nxt = S_INDEX;
            end
          end
          ACT_JNP: begin
            if (frame_s < ONE_S) begin
              res_status = ST_INVALID;
            end else begin
              height_new = height_r - HEIGHT_W'(1);
              if (a_zero) begin
                res_jt   = 1'b1;
                res_joff = arg_r;
              end
            end
          end
          ACT_JMP: begin
            res_jt   = 1'b1;
            res_joff = arg_r;
          end
          ACT_OP1: begin
            if ((frame_s < ONE_S) || (arg_r != SUB_NOT)) begin
              res_status = ST_INVALID;
            end else begin
              stk_we_req = 1'b1;
              stk_wdata  = WORD_W'(a_zero);
            end
          end
          ACT_OP2: begin
            if ((frame_s <= ONE_S) || arg_neg || (arg_r > SUB_NEQ)) begin
              res_status = ST_INVALID;
            end else begin
              stk_we_req = 1'b1;
              stk_waddr  = next_addr;
              stk_wdata  = WORD_W'(op2_r);
              height_new = height_r - HEIGHT_W'(1);
            end
          end
          ACT_CAL: begin
            res_status = (rem_ext > frame_s) ? ST_INVALID : ST_CALL;
          end
          ACT_RET: begin
            if (arg_s > frame_s) begin
              res_status = ST_INVALID;
            end else if (arg_s == '0) begin
              res_status = ST_RETURNED;
              res_rv     = NIL_WORD;
            end else if (arg_s == ONE_S) begin
              res_status = ST_RETURNED;
              res_rv     = stk_rd_a;
              height_new = height_r - HEIGHT_W'(1);
            end else begin
              res_status = ST_INVALID;
            end
          end
          default: begin
            res_status = ST_INVALID;
          end
        endcase
        if (done && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_INDEX: begin
        if (!idx_ok) begin
          done       = 1'b1;
          res_status = ST_INVALID;
          if (out_free) begin
            state_nxt = S_IDLE;
          end
        end else if (act_r == ACT_LDI) begin
          state_nxt = S_LOAD;
        end else begin
          // sti: value on top goes to the entity slot, both entries leave
          done       = 1'b1;
          var_we_req = 1'b1;
          var_waddr  = idx_s[VAR_AW-1:0];
          height_new = height_r - HEIGHT_W'(2);
          if (out_free) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        done       = 1'b1;
        stk_we_req = 1'b1;
        stk_wdata  = var_rd_b;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    finish        = done && out_free;
    stk_we        = stk_we_req && finish;
    var_we        = var_we_req && (finish || (state_r == S_CLEAR));
    height_nxt    = finish ? height_new : height_r;
    out_valid_nxt = finish ? 1'b1 : (out_valid_r && out_stall);
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_GLOBAL_COUNT:   cfg_prdata = CFG_DW'(gc_r);
      REG_PROPERTY_COUNT: cfg_prdata = CFG_DW'(pc_r);
      REG_VARIABLE_COUNT: cfg_prdata = CFG_DW'(vc_r);
      REG_FRAME_BASE:     cfg_prdata = CFG_DW'(fb_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      height_r    <= '0;
      out_valid_r <= 1'b0;
      gc_r        <= GC_RESET;
      pc_r        <= PC_RESET;
      vc_r        <= VC_RESET;
      fb_r        <= FB_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        act_r <= action_t'(in_action);
        arg_r <= in_operand;
      end
      if (state_r == S_EXEC) begin
        product_r <= product_nxt;
      end
      if (finish) begin
        out_status_r <= res_status;
        out_jt_r     <= res_jt;
        out_joff_r   <= res_joff;
        out_rv_r     <= res_rv;
      end
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_GLOBAL_COUNT:   gc_r <= cfg_pwdata[GC_W-1:0];
          REG_PROPERTY_COUNT: pc_r <= cfg_pwdata[PC_W-1:0];
          REG_VARIABLE_COUNT: vc_r <= cfg_pwdata[VC_W-1:0];
          REG_FRAME_BASE:     fb_r <= cfg_pwdata[FB_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_jump_taken   = out_jt_r;
  assign out_jump_offset  = out_joff_r;
  assign out_return_value = out_rv_r;

endmodule

`default_nettype wire

/* design/sbe_chk.sv */
// port-level checker for the stack bytecode executor, bound to the top level
// depends on sbe_pkg
`default_nettype none

module sbe_chk
  import sbe_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [STAT_W-1:0]        out_status,
  input wire logic                     out_jump_taken,
  input wire logic signed [OPND_W-1:0] out_jump_offset,
  input wire logic signed [WORD_W-1:0] out_return_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_jump_offset) && $stable(out_return_value))
    else $error("stalled result changed");

  // no second transfer while the previous instruction executes
  a_in_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while executing");

  a_rv_only_on_return: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_RETURNED) |-> out_return_value == '0)
    else $error("return value without return status");

  a_offset_only_on_jump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_jump_taken |-> out_jump_offset == '0)
    else $error("jump offset without jump");

endmodule

bind stack_bytecode_executor sbe_chk u_sbe_chk (.*);

`default_nettype wire

/* tb/tb_stack_bytecode_executor.sv */
// testbench for stack_bytecode_executor: directed and random instruction streams,
// checked result by result against an in-bench model of stack, variable store and registers
// depends on sbe_pkg and the executor rtl
module tb_stack_bytecode_executor;
  import sbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int OPND_MAX    = (1 << (OPND_W - 1)) - 1;
  localparam int OPND_MIN    = -(1 << (OPND_W - 1));
  localparam int ARG_WRAP    = 256;
  localparam int HEIGHT_CAP  = 48;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [OPND_W-1:0] operand;
  } instr_t;

  typedef struct packed {
    status_t             status;
    logic                jump_taken;
    logic [OPND_W-1:0]   jump_offset;
    logic [WORD_W-1:0]   return_value;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action = '0;
  logic [OPND_W-1:0] in_operand = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic              out_jump_taken;
  logic [OPND_W-1:0] out_jump_offset;
  logic [WORD_W-1:0] out_return_value;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // model state
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_W-1:0] var_mem [VARIABLE_DEPTH];
  int stk_height;
  int glob_count;
  int prop_count;
  int var_count;
  int frame_base;

  instr_t   instr_queue[$];
  outcome_t results_due[$];

  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  always #5 clk = ~clk;

  stack_bytecode_executor i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_operand       (in_operand),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_jump_taken   (out_jump_taken),
    .out_jump_offset  (out_jump_offset),
    .out_return_value (out_return_value),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  function automatic bit has_room();
    return stk_height < PUSH_LIMIT && stk_height < STACK_DEPTH;
  endfunction

  function automatic void push_word(logic [WORD_W-1:0] w);
    stk_mem[stk_height] = w;
    stk_height++;
  endfunction

  // globals + properties * entity + offset, wide enough that nothing wraps
  function automatic longint entity_index(logic [WORD_W-1:0] ent, int off);
    return longint'(glob_count) + longint'(prop_count) * longint'($signed(ent)) + longint'(off);
  endfunction

  function automatic outcome_t execute_instr(action_t act, logic signed [OPND_W-1:0] opnd);
    outcome_t res;
    int arg;
    int frame;
    longint nvar;
    longint idx;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] r;
    bit op_ok;
    res = '{ST_CONTINUE, 1'b0, '0, '0};
    arg = opnd;
    frame = stk_height - frame_base;
    nvar = (var_count < VARIABLE_DEPTH) ? var_count : VARIABLE_DEPTH;
    case (act)
      ACT_LLI: begin
        if (!has_room()) res.status = ST_OVERFLOW;
        else push_word(arg);
      end
      ACT_POP: begin
        if (arg < 0 || arg > frame) res.status = ST_INVALID;
        else stk_height -= arg;
      end
      ACT_LDL: begin
        if (arg < 0 || arg >= frame) res.status = ST_INVALID;
        else if (!has_room()) res.status = ST_OVERFLOW;
        else push_word(stk_mem[frame_base + arg]);
      end
      ACT_STL: begin
        if (arg < 0 || arg >= frame - 1) res.status = ST_INVALID;
        else begin
          a = stk_mem[stk_height - 1];
          stk_height--;
          stk_mem[frame_base + arg] = a;
        end
      end
      ACT_LDG: begin
        if (arg < 0 || arg >= nvar) res.status = ST_INVALID;
        else if (!has_room()) res.status = ST_OVERFLOW;
        else push_word(var_mem[arg]);
      end
      ACT_STG: begin
        if (arg < 0 || arg >= nvar || frame < 1) res.status = ST_INVALID;
        else begin
          stk_height--;
          var_mem[arg] = stk_mem[stk_height];
        end
      end
      ACT_LDI: begin
        if (frame < 1) res.status = ST_INVALID;
        else begin
          idx = entity_index(stk_mem[stk_height - 1], arg);
          if (idx < 0 || idx >= nvar) res.status = ST_INVALID;
          else stk_mem[stk_height - 1] = var_mem[idx];
        end
      end
      ACT_STI: begin
        if (frame < 2) res.status = ST_INVALID;
        else begin
          idx = entity_index(stk_mem[stk_height - 2], arg);
          if (idx < 0 || idx >= nvar) res.status = ST_INVALID;
          else begin
            var_mem[idx] = stk_mem[stk_height - 1];
            stk_height -= 2;
          end
        end
      end
      ACT_JNP: begin
        if (frame < 1) res.status = ST_INVALID;
        else begin
          stk_height--;
          if (stk_mem[stk_height] == '0) begin
            res.jump_taken = 1'b1;
            res.jump_offset = opnd;
          end
        end
      end
      ACT_JMP: begin
        res.jump_taken = 1'b1;
        res.jump_offset = opnd;
      end
      ACT_OP1: begin
        if (frame < 1 || opnd != SUB_NOT) res.status = ST_INVALID;
        else stk_mem[stk_height - 1] = (stk_mem[stk_height - 1] == '0) ? 1 : 0;
      end
      ACT_OP2: begin
        if (frame < 2) res.status = ST_INVALID;
        else begin
          a = stk_mem[stk_height - 1];
          b = stk_mem[stk_height - 2];
          op_ok = 1'b1;
          r = '0;
          case (opnd)
            SUB_AND: r = (a != '0 && b != '0);
            SUB_OR:  r = (a != '0 || b != '0);
            SUB_EQ:  r = (a == b);
            SUB_NEQ: r = (a != b);
            default: op_ok = 1'b0;
          endcase
          if (!op_ok) res.status = ST_INVALID;
          else begin
            stk_height--;
            stk_mem[stk_height - 1] = r;
          end
        end
      end
      ACT_CAL: begin
        // truncating remainder, so negative operands stay negative
        if ((arg % ARG_WRAP) > frame) res.status = ST_INVALID;
        else res.status = ST_CALL;
      end
      ACT_RET: begin
        if (arg > frame) res.status = ST_INVALID;
        else if (arg == 0) begin
          res.status = ST_RETURNED;
          res.return_value = NIL_WORD;
        end else if (arg == 1) begin
          res.status = ST_RETURNED;
          stk_height--;
          res.return_value = stk_mem[stk_height];
        end else res.status = ST_INVALID;
      end
      default: res.status = ST_INVALID;
    endcase
    return res;
  endfunction

  function automatic int pick_operand();
    case ($urandom_range(0, 8))
      0, 1: return 0;
      2: return 1;
      3: return $urandom_range(2, 15);
      4: return int'($urandom_range(0, 6)) - 3;
      5: return $urandom_range(0, 1) ? OPND_MAX : OPND_MIN;
      default: return $signed($urandom) >>> 8;
    endcase
  endfunction

  task automatic send(action_t act, int opnd);
    instr_t it;
    it.action = act;
    it.operand = opnd[OPND_W-1:0];
    @(negedge clk);
    while (instr_queue.size() >= 3) @(negedge clk);
    instr_queue.push_back(it);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (instr_queue.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_GLOBAL_COUNT:   glob_count = val & ((1 << GC_W) - 1);
      REG_PROPERTY_COUNT: prop_count = val & ((1 << PC_W) - 1);
      REG_VARIABLE_COUNT: var_count = val & ((1 << VC_W) - 1);
      REG_FRAME_BASE:     frame_base = val & ((1 << FB_W) - 1);
      default: ;
    endcase
  endtask

  task automatic set_config(int gc, int pc, int vc, int fb);
    write_reg(REG_GLOBAL_COUNT, gc);
    write_reg(REG_PROPERTY_COUNT, pc);
    write_reg(REG_VARIABLE_COUNT, vc);
    write_reg(REG_FRAME_BASE, fb);
  endtask

  // entity on the stack, optional value above it, then the property access;
  // the offset mostly aims at a valid variable
  task automatic entity_access(bit is_store);
    int nvar;
    int ent;
    int tgt;
    nvar = (var_count < VARIABLE_DEPTH) ? var_count : VARIABLE_DEPTH;
    ent = ($urandom_range(0, 7) == 0) ? pick_operand() : int'($urandom_range(0, 6)) - 3;
    if ($urandom_range(0, 7) == 0) tgt = $urandom_range(0, 1) ? nvar : -1;
    else tgt = (nvar > 0) ? $urandom_range(0, nvar - 1) : 0;
    send(ACT_LLI, ent);
    if (is_store) send(ACT_LLI, pick_operand());
    send(is_store ? ACT_STI : ACT_LDI, tgt - glob_count - prop_count * ent);
  endtask

  task automatic random_instr();
    int frame;
    int nvar;
    int sel;
    frame = stk_height - frame_base;
    nvar = (var_count < VARIABLE_DEPTH) ? var_count : VARIABLE_DEPTH;
    sel = $urandom_range(0, 99);
    if (sel < 6) send(action_t'($urandom_range(0, 15)), pick_operand());
    else if (stk_height > HEIGHT_CAP && frame >= 1) send(ACT_POP, $urandom_range(1, frame));
    else if (sel < 28) send(ACT_LLI, pick_operand());
    else if (sel < 34) send(ACT_LDL, (frame >= 1) ? $urandom_range(0, frame - 1) : pick_operand());
    else if (sel < 39) send(ACT_STL, (frame >= 2) ? $urandom_range(0, frame - 2) : $urandom_range(0, 2));
    else if (sel < 45)
      send(ACT_LDG, (nvar > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, nvar - 1) : pick_operand());
    else if (sel < 50)
      send(ACT_STG, (nvar > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, nvar - 1) : pick_operand());
    else if (sel < 56) entity_access(1'b0);
    else if (sel < 61) entity_access(1'b1);
    else if (sel < 67) send(ACT_JNP, pick_operand());
    else if (sel < 70) send(ACT_JMP, pick_operand());
    else if (sel < 74) send(ACT_OP1, ($urandom_range(0, 7) == 0) ? pick_operand() : int'(SUB_NOT));
    else if (sel < 82)
      send(ACT_OP2, ($urandom_range(0, 7) == 0) ? pick_operand()
                                                 : $urandom_range(int'(SUB_AND), int'(SUB_NEQ)));
    else if (sel < 86)
      send(ACT_CAL, int'($urandom_range(0, 10)) - 2 + ($urandom_range(0, 1) ? ARG_WRAP : 0));
    else if (sel < 93) begin
      case ($urandom_range(0, 5))
        0, 1, 2: send(ACT_RET, 1);
        3: send(ACT_RET, 0);
        4: send(ACT_RET, $urandom_range(2, 4));
        default: send(ACT_RET, pick_operand());
      endcase
    end else send(ACT_POP, $urandom_range(0, 2));
  endtask

  task automatic run_random(int count);
    repeat (count) random_instr();
    wait_idle();
  endtask

  // sender: bursts of transfers with gaps between them
  always @(posedge clk) begin : drive_instr
    instr_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        results_due.push_back(execute_instr(action_t'(in_action), in_operand));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (instr_queue.size() != 0) begin
          nxt = instr_queue.pop_front();
          in_valid <= 1'b1;
          in_action <= nxt.action;
          in_operand <= nxt.operand;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer and stalls in changing patterns
  always @(posedge clk) begin : check_results
    outcome_t got;
    outcome_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.jump_taken = out_jump_taken;
        got.jump_offset = out_jump_offset;
        got.return_value = out_return_value;
        if (results_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: status %0d jump %0b offset %0d value %0d",
                     got.status, got.jump_taken, $signed(got.jump_offset),
                     $signed(got.return_value));
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.jump_taken !== want.jump_taken ||
              got.jump_offset !== want.jump_offset || got.return_value !== want.return_value) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch (exp/got): status %0d/%0d jump %0b/%0b offset %0d/%0d value %0d/%0d",
                       want.status, got.status, want.jump_taken, got.jump_taken,
                       $signed(want.jump_offset), $signed(got.jump_offset),
                       $signed(want.return_value), $signed(got.return_value));
          end
        end
      end
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_timer = $urandom_range(50, 300);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cycle_count % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stack_bytecode_executor: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    foreach (var_mem[i]) var_mem[i] = NIL_WORD;
    foreach (stk_mem[i]) stk_mem[i] = '0;
    stk_height = 0;
    glob_count = GC_RESET;
    prop_count = PC_RESET;
    var_count = VC_RESET;
    frame_base = FB_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // small store, stride 3, frame at the bottom
    set_config(2, 3, 16, 0);
    send(ACT_RET, 0);
    send(ACT_POP, 1);
    send(ACT_STG, 0);
    send(ACT_JNP, 5);
    send(ACT_CAL, 1);
    send(ACT_LLI, OPND_MAX);
    send(ACT_LLI, OPND_MIN);
    send(ACT_OP2, SUB_EQ);
    send(ACT_OP1, SUB_NOT);
    send(ACT_LLI, 0);
    send(ACT_OP2, SUB_AND);
    send(ACT_LDG, 0);
    send(ACT_OP2, SUB_OR);
    send(ACT_STG, 15);
    send(ACT_LDG, 16);
    send(ACT_LLI, 1);
    send(ACT_LDI, 0);
    send(ACT_LLI, 77);
    send(ACT_STI, 14);
    send(ACT_LLI, -1);
    send(ACT_LDI, 14);
    send(ACT_LDL, 0);
    send(ACT_STL, 1);
    send(ACT_OP2, int'(SUB_NEQ) + 1);
    send(ACT_JNP, 100);
    send(ACT_LLI, 0);
    send(ACT_JNP, -100);
    send(ACT_JMP, OPND_MIN);
    send(ACT_OP1, 1);
    send(ACT_OP3, 0);
    send(ACT_INV, 0);
    send(ACT_CAL, -1);
    send(ACT_RET, 2);
    send(ACT_RET, 1);
    run_random(100);

    // no variables at all
    set_config(0, 0, 0, 0);
    run_random(40);

    // largest property count and full store, entities only reachable with negative ids
    set_config(4096, 255, 4096, 0);
    run_random(100);

    // frame above part of the stack
    repeat (8) send(ACT_LLI, pick_operand());
    wait_idle();
    set_config(100, 7, 1000, (stk_height > 3) ? stk_height - 3 : 0);
    run_random(150);

    // frame beyond any reachable height
    write_reg(REG_FRAME_BASE, STACK_DEPTH);
    run_random(25);

    // fill up to the push limit, then push against it
    set_config(8, 1, 4096, 0);
    for (int n = stk_height; n < PUSH_MAX; n++) begin
      if (n > 0 && $urandom_range(0, 7) == 0) send(ACT_LDL, $urandom_range(0, n - 1));
      else send(ACT_LLI, pick_operand());
    end
    send(ACT_LLI, 5);
    send(ACT_LDL, 0);
    send(ACT_LDL, PUSH_MAX);
    send(ACT_LDG, 0);
    send(ACT_JMP, OPND_MAX);
    send(ACT_RET, 1);
    send(ACT_LLI, 7);
    send(ACT_LLI, 8);
    send(ACT_OP2, SUB_EQ);
    send(ACT_CAL, 300);
    wait_idle();
    send(ACT_POP, stk_height);
    wait_idle();

    set_config(13, 200, 4095, stk_height);
    run_random(100);

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_stack_bytecode_executor: done, clean");
    end else begin
      $display("tb_stack_bytecode_executor: done, errors");
    end
    $finish;
  end

endmodule
